// File: design/afp_pkg.sv
// Shared constants and types for the acknowledge frame parser.
package afp_pkg;

  // Header layout
  localparam int unsigned HDR_LEN         = 9;
  localparam int unsigned HDR_POS_SYNC_HI = 0;
  localparam int unsigned HDR_POS_SYNC_LO = 1;
  localparam int unsigned HDR_POS_TYPE    = 6;
  localparam int unsigned HDR_POS_LEN_HI  = 7;

  localparam logic [7:0] SYNC_HI  = 8'hEF;
  localparam logic [7:0] SYNC_LO  = 8'h01;
  localparam logic [7:0] TYPE_ACK = 8'h07;
  localparam logic [7:0] MIN_BODY = 8'd3;

  localparam int unsigned MAX_PAYLOAD_W = 5;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

endpackage

// File: design/ack_frame_parser_core.sv
// Acknowledge frame parser: header check, body walk and result register.
// Usage:
//   Input channel: one received serial byte per item on rx_byte_i, qualified
//   by in_valid_i; the item is taken at a clock edge where in_stall_o is low.
//   Output channel: one result item on out_kind_o/out_byte_o/out_last_o,
//   qualified by out_valid_o; the receiver holds out_stall_i high to stall.
//   Config channel: cfg_max_payload_i is written at an edge with cfg_valid_i
//   and cfg_ready_o high. It sets how many payload bytes per frame pass out.
//   Write it only while the parser is idle.
// Timing and throughput:
//   A byte that causes a result shows it on the output in the cycle after
//   it is taken. One byte is taken every cycle unless stalled; the single
//   result register, the only buffer, refills in the same cycle it drains.
// Reset:
//   rst_ni clears the parser to the start of a header, empties the result
//   register and sets max_payload to zero.
// Stall:
//   While the result register holds an item that the receiver stalls,
//   in_stall_o is high and no byte is taken; the result holds steady.
//   Bytes that cause no result wait the same way.
module ack_frame_parser_core #(
  parameter int unsigned BODY_MAX = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // received bytes
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           rx_byte_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           out_kind_o,
  output logic [7:0]                           out_byte_o,
  output logic                                 out_last_o,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [afp_pkg::MAX_PAYLOAD_W-1:0]    cfg_max_payload_i
);
  import afp_pkg::*;

  // Body length register width and position counter width.
  localparam int unsigned LenW = $clog2(BODY_MAX + 1);
  localparam int unsigned PosW = (LenW > 4) ? LenW : 4;

  logic [MAX_PAYLOAD_W-1:0] max_payload_q;
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     in_body_q, in_body_d;
  logic                     hdr_bad_q, hdr_bad_d;
  logic                     len_hi_q, len_hi_d;
  logic [LenW-1:0]          body_len_q, body_len_d;
  logic [7:0]               confirm_q, confirm_d;

  logic                     out_valid_q, out_valid_d;
  kind_e                    out_kind_q;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;

  // Result of the byte at the input, before the result register.
  logic                     res_valid;
  kind_e                    res_kind;
  logic [7:0]               res_byte;
  logic                     res_last;

  logic                     in_acc;
  logic [7:0]               pos_w;
  logic [7:0]               len_w;
  logic                     hdr_bad_now;
  logic                     len_hi_now;

  assign cfg_ready_o = 1'b1;
  // Take a byte whenever the result register is empty or draining.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign pos_w = 8'(pos_q);
  assign len_w = 8'(body_len_q);

  // Sync, type and length-high checks on the current header byte.
  always_comb begin
    hdr_bad_now = 1'b0;
    len_hi_now  = 1'b0;
    if (pos_q == PosW'(HDR_POS_SYNC_HI)) begin
      hdr_bad_now = (rx_byte_i != SYNC_HI);
    end else if (pos_q == PosW'(HDR_POS_SYNC_LO)) begin
      hdr_bad_now = (rx_byte_i != SYNC_LO);
    end else if (pos_q == PosW'(HDR_POS_TYPE)) begin
      hdr_bad_now = (rx_byte_i != TYPE_ACK);
    end else if (pos_q == PosW'(HDR_POS_LEN_HI)) begin
      len_hi_now  = (rx_byte_i != 8'd0);
    end
  end

  // Parser next state and result for one byte.
  always_comb begin
    pos_d      = pos_q;
    in_body_d  = in_body_q;
    hdr_bad_d  = hdr_bad_q;
    len_hi_d   = len_hi_q;
    body_len_d = body_len_q;
    confirm_d  = confirm_q;
    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_byte   = rx_byte_i;
    res_last   = 1'b0;

    if (!in_body_q) begin
      hdr_bad_d = hdr_bad_q | hdr_bad_now;
      len_hi_d  = len_hi_q | len_hi_now;
      if (pos_q != PosW'(HDR_LEN - 1)) begin
        pos_d = pos_q + PosW'(1);
      end else if (hdr_bad_q || len_hi_q || rx_byte_i < MIN_BODY ||
                   rx_byte_i > 8'(BODY_MAX)) begin
        // Reject the header and restart.
        pos_d     = '0;
        hdr_bad_d = 1'b0;
        len_hi_d  = 1'b0;
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
        res_byte  = 8'd0;
        res_last  = 1'b1;
      end else begin
        body_len_d = rx_byte_i[LenW-1:0];
        pos_d      = '0;
        in_body_d  = 1'b1;
      end
    end else begin
      if (pos_q == '0) begin
        confirm_d = rx_byte_i;
        pos_d     = PosW'(1);
      end else if (pos_w + 8'd1 >= len_w) begin
        // Last checksum byte: close the frame.
        pos_d     = '0;
        in_body_d = 1'b0;
        hdr_bad_d = 1'b0;
        len_hi_d  = 1'b0;
        res_valid = 1'b1;
        res_kind  = KIND_DONE;
        res_byte  = confirm_q;
        res_last  = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
        // Pass payload bytes up to the configured count; drop the rest.
        if (pos_w + 8'd2 < len_w && pos_w - 8'd1 < 8'(max_payload_q)) begin
          res_valid = 1'b1;
        end
      end
    end
  end

  // Result register valid: load on a taken byte, clear when drained.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= '0;
      pos_q         <= '0;
      in_body_q     <= 1'b0;
      hdr_bad_q     <= 1'b0;
      len_hi_q      <= 1'b0;
      body_len_q    <= '0;
      confirm_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_payload_q <= cfg_max_payload_i;
      end
      if (in_acc) begin
        pos_q      <= pos_d;
        in_body_q  <= in_body_d;
        hdr_bad_q  <= hdr_bad_d;
        len_hi_q   <= len_hi_d;
        body_len_q <= body_len_d;
        confirm_q  <= confirm_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // A framing error carries a zero byte and ends the frame.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_ERROR |-> out_byte_o == 8'd0 && out_last_o)
    else $error("framing error result with bad fields");

  // Only frame-ending results carry out_last.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_last_o == (out_kind_o != KIND_PAYLOAD))
    else $error("out_last does not match kind");

  // Input is only held back by a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // A header byte never yields a payload result.
  a_hdr_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_body_q |=>
      !(out_valid_o && out_kind_o == KIND_PAYLOAD))
    else $error("payload result from a header byte");

  // An accepted body length lies within the legal range.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> len_w >= MIN_BODY && len_w <= 8'(BODY_MAX))
    else $error("body length out of range in body phase");

endmodule
